/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the k-mer counter.
// Assertions are compiled unless SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/kfc_pkg.sv */
// Types, constants and helper functions of the k-mer frequency counter.
// No dependencies; used by kfc_count_ram and kmer_frequency_counter_top.
`default_nettype none
package kfc_pkg;

  localparam int MAX_K        = 8;
  localparam int COUNT_BITS   = 32;
  localparam int CODE_W       = 2 * MAX_K;
  localparam int K_W          = 4;
  localparam int TOTAL_W      = 32;
  localparam int DISTINCT_W   = 17;
  localparam int OUT_COUNT_W  = 32;
  localparam int PADDR_W      = 3;

  // request codes
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // register index
  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic [K_W-1:0] KMER_LENGTH_RST = K_W'(4);

  // work carried by the lookup stage
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic                  en;
    logic [CODE_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } wr_req_t;

  function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] len);
    logic [K_W-1:0] k;
    if (len == '0) begin
      k = K_W'(1);
    end else if (len > K_W'(MAX_K)) begin
      k = K_W'(MAX_K);
    end else begin
      k = len;
    end
    return k;
  endfunction

  function automatic logic [CODE_W-1:0] code_mask(input logic [K_W-1:0] k);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (K_W'(i) < k) begin
        m[2*i +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* sv/kmer_frequency_counter_top.sv */
// k-mer frequency counter: an accepted item passes the lookup stage and the
// output register; one item per cycle while the output does not stall, set
// by the read-modify-write of the count store (read at accept, update and
// write back in the lookup stage). Reset: window, totals and k (4) reset at
// once; then all 65536 count store entries are swept to zero, during which
// no item is accepted (register writes are taken). Uses kfc_pkg, kfc_count_ram.
`default_nettype none
`include "assert_macros.svh"
module kmer_frequency_counter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [1:0]                      base_code_i,
  input  wire logic [15:0]                     query_code_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [15:0]                          kmer_code_o,
  output logic [kfc_pkg::OUT_COUNT_W-1:0]      kmer_count_o,
  output logic                                 window_valid_o,
  output logic [kfc_pkg::TOTAL_W-1:0]          total_windows_o,
  output logic [kfc_pkg::DISTINCT_W-1:0]       unique_kmers_o,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [kfc_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam logic [kfc_pkg::COUNT_BITS-1:0] ENTRY_MAX    = '1;
  localparam logic [kfc_pkg::TOTAL_W-1:0]    TOTAL_MAX    = '1;
  localparam logic [kfc_pkg::DISTINCT_W-1:0] DISTINCT_MAX = '1;

  logic                        cfg_wr;
  logic [kfc_pkg::K_W-1:0]     kmer_length_q, kmer_length_d;
  logic [kfc_pkg::K_W-1:0]     k_eff;
  logic [kfc_pkg::CODE_W-1:0]  mask;

  logic [kfc_pkg::CODE_W-1:0]  win_q, win_d, win_push;
  logic [kfc_pkg::K_W-1:0]     seen_q, seen_d, seen_push;

  logic                        in_xfer, clearing, s1_adv;
  kfc_pkg::op_e                s0_op;
  logic [kfc_pkg::CODE_W-1:0]  s0_code;

  logic                        s1_valid_q, s1_valid_d;
  kfc_pkg::op_e                s1_op_q;
  logic [kfc_pkg::CODE_W-1:0]  s1_code_q;

  logic [kfc_pkg::COUNT_BITS-1:0] rd_data, entry_inc, s1_count;
  kfc_pkg::wr_req_t               wr_req;

  logic [kfc_pkg::TOTAL_W-1:0]    total_q, total_d;
  logic [kfc_pkg::DISTINCT_W-1:0] distinct_q, distinct_d;

  logic                               out_valid_q, out_valid_d;
  logic [kfc_pkg::CODE_W-1:0]         out_code_q;
  logic [kfc_pkg::OUT_COUNT_W-1:0]    out_count_q;
  logic                               out_wv_q;
  logic [kfc_pkg::TOTAL_W-1:0]        out_total_q;
  logic [kfc_pkg::DISTINCT_W-1:0]     out_distinct_q;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == kfc_pkg::REG_KMER_LENGTH);
  assign prdata = (paddr[2] == kfc_pkg::REG_KMER_LENGTH) ? 32'(kmer_length_q) : '0;
  assign kmer_length_d = cfg_wr ? pwdata[kfc_pkg::K_W-1:0] : kmer_length_q;

  assign k_eff = kfc_pkg::eff_k(kmer_length_q);
  assign mask  = kfc_pkg::code_mask(k_eff);

  // handshake: the lookup stage moves on when the output register frees
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~clearing & (~s1_valid_q | s1_adv);
  assign in_xfer    = in_valid_i & in_ready_o;

  // window update at accept
  assign win_push  = ((win_q << 2) & mask) | kfc_pkg::CODE_W'(base_code_i);
  assign seen_push = (seen_q < k_eff) ? seen_q + 1'b1 : seen_q;

  always_comb begin
    s0_op   = kfc_pkg::OP_NONE;
    s0_code = '0;
    win_d   = win_q;
    seen_d  = seen_q;
    if (in_xfer) begin
      unique case (req_type_i)
        kfc_pkg::REQ_PUSH: begin
          win_d   = win_push;
          seen_d  = seen_push;
          s0_code = win_push;
          s0_op   = (seen_push >= k_eff) ? kfc_pkg::OP_COUNT : kfc_pkg::OP_NONE;
        end
        kfc_pkg::REQ_READ: begin
          s0_code = query_code_i & mask;
          s0_op   = kfc_pkg::OP_READ;
        end
        kfc_pkg::REQ_RESTART: begin
          win_d  = '0;
          seen_d = '0;
        end
        default: begin
          // unused request: no state change
        end
      endcase
    end
    if (cfg_wr) begin
      win_d  = '0;
      seen_d = '0;
    end
  end

  assign s1_valid_d = in_xfer | (s1_valid_q & ~s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= kfc_pkg::KMER_LENGTH_RST;
      win_q         <= '0;
      seen_q        <= '0;
      s1_valid_q    <= 1'b0;
      total_q       <= '0;
      distinct_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      kmer_length_q <= kmer_length_d;
      win_q         <= win_d;
      seen_q        <= seen_d;
      s1_valid_q    <= s1_valid_d;
      total_q       <= total_d;
      distinct_q    <= distinct_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= s0_op;
      s1_code_q <= s0_code;
    end
  end

  kfc_count_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_addr_i  (s0_code),
    .rd_data_o  (rd_data),
    .wr_i       (wr_req),
    .clearing_o (clearing)
  );

  // lookup stage: modify and write back
  assign entry_inc = (rd_data == ENTRY_MAX) ? rd_data : rd_data + 1'b1;

  always_comb begin
    wr_req      = '0;
    wr_req.addr = s1_code_q;
    wr_req.data = entry_inc;
    total_d     = total_q;
    distinct_d  = distinct_q;
    s1_count    = '0;
    if (s1_valid_q) begin
      unique case (s1_op_q)
        kfc_pkg::OP_COUNT: begin
          s1_count  = entry_inc;
          wr_req.en = s1_adv;
          if (s1_adv) begin
            if (total_q != TOTAL_MAX) begin
              total_d = total_q + 1'b1;
            end
            if (rd_data == '0 && distinct_q != DISTINCT_MAX) begin
              distinct_d = distinct_q + 1'b1;
            end
          end
        end
        kfc_pkg::OP_READ: begin
          s1_count = rd_data;
        end
        default: begin
          s1_count = '0;
        end
      endcase
    end
  end

  // output register
  assign out_valid_d = s1_adv | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_code_q     <= s1_code_q;
      out_count_q    <= s1_count[kfc_pkg::OUT_COUNT_W-1:0];
      out_wv_q       <= (s1_op_q == kfc_pkg::OP_COUNT);
      out_total_q    <= total_d;
      out_distinct_q <= distinct_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kmer_code_o     = out_code_q;
  assign kmer_count_o    = out_count_q;
  assign window_valid_o  = out_wv_q;
  assign total_windows_o = out_total_q;
  assign unique_kmers_o  = out_distinct_q;

  `ASSERT_ALWAYS(a_no_accept_clearing, clk_i, clearing |-> !in_ready_o, "item taken during clear")
  `ASSERT_RST(a_total_monotonic, clk_i, rst_ni, 1'b1 |=> total_q >= $past(total_q), "total fell")
  `ASSERT_RST(a_distinct_le_total, clk_i, rst_ni, 32'(distinct_q) <= total_q, "distinct over total")
  `ASSERT_RST(a_counted_nonzero, clk_i, rst_ni, (out_valid_q && out_wv_q) |-> out_count_q != '0, "counted window with zero count")

endmodule
`default_nettype wire

/* sv/kfc_count_ram.sv */
// Count store: one-write, one-read synchronous memory with a clearing sweep
// after reset and forwarding of the latest write. Uses kfc_pkg.
`default_nettype none
module kfc_count_ram (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rd_en_i,
  input  wire logic [kfc_pkg::CODE_W-1:0]     rd_addr_i,
  output logic      [kfc_pkg::COUNT_BITS-1:0] rd_data_o,
  input  wire kfc_pkg::wr_req_t               wr_i,
  output logic                                clearing_o
);

  localparam int DEPTH = 1 << kfc_pkg::CODE_W;

  logic [kfc_pkg::COUNT_BITS-1:0] mem [DEPTH];

  logic                           clr_q, clr_d;
  logic [kfc_pkg::CODE_W-1:0]     clr_addr_q, clr_addr_d;
  logic [kfc_pkg::COUNT_BITS-1:0] rd_raw_q;
  logic [kfc_pkg::CODE_W-1:0]     rd_addr_q;
  logic                           lw_valid_q, lw_valid_d;
  logic [kfc_pkg::CODE_W-1:0]     lw_addr_q;
  logic [kfc_pkg::COUNT_BITS-1:0] lw_data_q;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_d = 1'b0;
      end
    end
    lw_valid_d = lw_valid_q | (wr_i.en & ~clr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      lw_valid_q <= lw_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_raw_q  <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // remember the latest write; a read taken at the same edge saw the old word
  always_ff @(posedge clk_i) begin
    if (wr_i.en && !clr_q) begin
      lw_addr_q <= wr_i.addr;
      lw_data_q <= wr_i.data;
    end
  end

  assign rd_data_o  = (lw_valid_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_raw_q;
  assign clearing_o = clr_q;

endmodule
`default_nettype wire
